// File: hw/rtl/gqtm_pkg.sv
// Package with the quad, pair and setup types of the grid quad texture mapper.
`default_nettype none
package gqtm_pkg;

  localparam int unsigned TILE_WIDTH_LOG2_DEF  = 3;
  localparam int unsigned TILE_HEIGHT_LOG2_DEF = 3;
  localparam int unsigned SHADE_FRAC_SHIFT     = 3;
  localparam int unsigned QUEUE_DEPTH          = 2;

  typedef struct packed {
    logic signed [15:0] tl_u;
    logic signed [15:0] tl_v;
    logic        [18:0] tl_shade;
    logic signed [15:0] tr_u;
    logic signed [15:0] tr_v;
    logic        [18:0] tr_shade;
    logic signed [15:0] bl_u;
    logic signed [15:0] bl_v;
    logic        [18:0] bl_shade;
    logic signed [15:0] br_u;
    logic signed [15:0] br_v;
    logic        [18:0] br_shade;
  } quad_t;

  typedef struct packed {
    logic [15:0] first_tex_index;
    logic [2:0]  first_shift;
    logic [15:0] second_tex_index;
    logic [2:0]  second_shift;
    logic        last;
  } pair_t;

  // Per-quad setup: start values and per-row increments.
  typedef struct packed {
    logic [31:0] left_uv;
    logic [31:0] left_uv_step;
    logic [31:0] top_du;
    logic [31:0] top_dv;
    logic [31:0] du_row_step;
    logic [31:0] dv_row_step;
    logic [31:0] left_shade;
    logic [31:0] left_shade_step;
    logic [31:0] shade_dx;
    logic [31:0] shade_dx_step;
  } setup_t;

  // Handshake between the front end and the setup queue.
  typedef struct packed {
    logic   valid;
    setup_t data;
  } setup_beat_t;

endpackage
`default_nettype wire

// File: hw/rtl/gqtm_if.sv
// Valid/ready channel interfaces for quads in and pixel pairs out.
`default_nettype none
interface gqtm_quad_if;
  logic            valid;
  logic            ready;
  gqtm_pkg::quad_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gqtm_pair_if;
  logic            valid;
  logic            ready;
  gqtm_pkg::pair_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/gqtm_front.sv
// Front end: turns a quad beat into its setup values.
`default_nettype none
module gqtm_front #(
  parameter int unsigned TILE_WIDTH_LOG2  = gqtm_pkg::TILE_WIDTH_LOG2_DEF,
  parameter int unsigned TILE_HEIGHT_LOG2 = gqtm_pkg::TILE_HEIGHT_LOG2_DEF
) (
  gqtm_quad_if.sink              quad_i,
  output gqtm_pkg::setup_beat_t  push_o,
  input  logic                   push_ready_i
);
  import gqtm_pkg::*;

  logic signed [31:0] tlu, tlv, tru, trv, blu, blv, bru, brv;
  logic signed [31:0] tls, trs, bls, brs;
  logic signed [31:0] du_l, dv_l, top_du, top_dv, du_diff, dv_diff;
  logic signed [31:0] ds_l, st, dd_diff, dd;
  logic [31:0]        du_ls, dv_ls;

  always_comb begin
    tlu = 32'(quad_i.data.tl_u);
    tlv = 32'(quad_i.data.tl_v);
    tru = 32'(quad_i.data.tr_u);
    trv = 32'(quad_i.data.tr_v);
    blu = 32'(quad_i.data.bl_u);
    blv = 32'(quad_i.data.bl_v);
    bru = 32'(quad_i.data.br_u);
    brv = 32'(quad_i.data.br_v);
    tls = $signed({13'd0, quad_i.data.tl_shade});
    trs = $signed({13'd0, quad_i.data.tr_shade});
    bls = $signed({13'd0, quad_i.data.bl_shade});
    brs = $signed({13'd0, quad_i.data.br_shade});

    du_l    = blu - tlu;
    dv_l    = blv - tlv;
    du_ls   = du_l >>> TILE_HEIGHT_LOG2;
    dv_ls   = dv_l >>> TILE_HEIGHT_LOG2;
    top_du  = tru - tlu;
    top_dv  = trv - tlv;
    du_diff = (bru - blu) - top_du;
    dv_diff = (brv - blv) - top_dv;
    ds_l    = bls - tls;
    st      = trs - tls;
    dd_diff = (brs - bls) - st;
    dd      = dd_diff >>> TILE_HEIGHT_LOG2;

    push_o.valid                = quad_i.valid;
    push_o.data.left_uv         = {tlu[15:0], tlv[15:0]};
    push_o.data.left_uv_step    = {du_ls[15:0], dv_ls[15:0]};
    push_o.data.top_du          = top_du;
    push_o.data.top_dv          = top_dv;
    push_o.data.du_row_step     = du_diff >>> TILE_HEIGHT_LOG2;
    push_o.data.dv_row_step     = dv_diff >>> TILE_HEIGHT_LOG2;
    push_o.data.left_shade      = tls;
    push_o.data.left_shade_step = ds_l >>> TILE_HEIGHT_LOG2;
    push_o.data.shade_dx        = st >>> TILE_WIDTH_LOG2;
    push_o.data.shade_dx_step   = dd >>> TILE_WIDTH_LOG2;
  end

  assign quad_i.ready = push_ready_i;

endmodule
`default_nettype wire

// File: hw/rtl/gqtm_queue.sv
// Short setup queue between front end and pixel stepper.
`default_nettype none
module gqtm_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gqtm_pkg::setup_beat_t push_i,
  output logic                  push_ready_o,
  output gqtm_pkg::setup_beat_t pop_o,
  input  logic                  pop_ready_i
);
  import gqtm_pkg::*;

  localparam int unsigned Depth = QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  setup_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_o.valid  = (cnt_q != '0);
  assign pop_o.data   = mem_q[rd_ptr_q];
  assign push         = push_i.valid && push_ready_o;
  assign pop          = pop_o.valid && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/gqtm_back.sv
// Back end: steps through the tile rows and emits one pixel pair per cycle when not stalled.
`default_nettype none
module gqtm_back #(
  parameter int unsigned TILE_WIDTH_LOG2  = gqtm_pkg::TILE_WIDTH_LOG2_DEF,
  parameter int unsigned TILE_HEIGHT_LOG2 = gqtm_pkg::TILE_HEIGHT_LOG2_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gqtm_pkg::setup_beat_t pop_i,
  output logic                  pop_ready_o,
  gqtm_pair_if.source           pair_o
);
  import gqtm_pkg::*;

  localparam int unsigned PairW = TILE_WIDTH_LOG2 - 1;
  localparam int unsigned RowW  = TILE_HEIGHT_LOG2;

  // Next-row values; the steps are held for the whole quad.
  setup_t           cur_q, cur_d;
  logic [31:0]      row_uv_q, duvdx_q, shade_pair_q, shade_step_q;
  logic [PairW-1:0] pair_cnt_q;
  logic [RowW-1:0]  row_cnt_q;
  logic             active_q, active_d;
  logic             out_valid_q, out_valid_d;
  pair_t            out_q;

  logic        adv, emit, load_new, step_row, step_pair;
  setup_t      src;
  logic [31:0] dudx, dvdx, sd32, s32, second_uv;
  logic [15:0] sd16, s16, sum16;
  logic [31:0] row_uv_n, duvdx_n, shade_pair_n, shade_step_n;
  pair_t       pair_n;

  always_comb begin
    adv       = !out_valid_q || pair_o.ready;
    emit      = 1'b0;
    load_new  = 1'b0;
    step_row  = 1'b0;
    step_pair = 1'b0;
    active_d  = active_q;
    if (active_q && adv) begin
      emit = 1'b1;
      if (!(&pair_cnt_q)) begin
        step_pair = 1'b1;
      end else if (!(&row_cnt_q)) begin
        step_row = 1'b1;
      end else if (pop_i.valid) begin
        load_new = 1'b1;
      end else begin
        active_d = 1'b0;
      end
    end else if (!active_q && pop_i.valid) begin
      load_new = 1'b1;
      active_d = 1'b1;
    end
    out_valid_d = adv ? emit : out_valid_q;
  end

  assign pop_ready_o = load_new;

  // Row start values from either a fresh quad or the held next-row state.
  always_comb begin
    src          = load_new ? pop_i.data : cur_q;
    dudx         = $signed(src.top_du) >>> TILE_WIDTH_LOG2;
    dvdx         = $signed(src.top_dv) >>> TILE_WIDTH_LOG2;
    sd32         = $signed(src.shade_dx) >>> SHADE_FRAC_SHIFT;
    s32          = $signed(src.left_shade) >>> SHADE_FRAC_SHIFT;
    sd16         = sd32[15:0];
    s16          = s32[15:0];
    sum16        = s16 + sd16;
    row_uv_n     = src.left_uv;
    duvdx_n      = {dudx[15:0], dvdx[15:0]};
    shade_pair_n = {sum16, s16};
    shade_step_n = {sd16[14:0], sd16, 1'b0};

    cur_d            = src;
    cur_d.left_uv    = src.left_uv + src.left_uv_step;
    cur_d.left_shade = src.left_shade + src.left_shade_step;
    cur_d.shade_dx   = src.shade_dx + src.shade_dx_step;
    cur_d.top_du     = src.top_du + src.du_row_step;
    cur_d.top_dv     = src.top_dv + src.dv_row_step;
  end

  always_comb begin
    second_uv               = row_uv_q + duvdx_q;
    pair_n.first_tex_index  = {row_uv_q[15:8], row_uv_q[31:24]};
    pair_n.first_shift      = shade_pair_q[15:13];
    pair_n.second_tex_index = {second_uv[15:8], second_uv[31:24]};
    pair_n.second_shift     = shade_pair_q[31:29];
    pair_n.last             = (&row_cnt_q) && (&pair_cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      pair_cnt_q  <= '0;
      row_cnt_q   <= '0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      if (load_new || step_row) begin
        pair_cnt_q <= '0;
        row_cnt_q  <= load_new ? '0 : row_cnt_q + 1'b1;
      end else if (step_pair) begin
        pair_cnt_q <= pair_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_new || step_row) begin
      cur_q        <= cur_d;
      row_uv_q     <= row_uv_n;
      duvdx_q      <= duvdx_n;
      shade_pair_q <= shade_pair_n;
      shade_step_q <= shade_step_n;
    end else if (step_pair) begin
      row_uv_q     <= row_uv_q + {duvdx_q[30:0], 1'b0};
      shade_pair_q <= shade_pair_q + shade_step_q;
    end
    if (emit) begin
      out_q <= pair_n;
    end
  end

  assign pair_o.valid = out_valid_q;
  assign pair_o.data  = out_q;

endmodule
`default_nettype wire

// File: hw/rtl/grid_quad_texture_mapper_top.sv
// Top level of the grid quad texture mapper: front end, setup queue, pixel stepper.
// A taken quad beat goes through the setup queue and stepper registers to the output.
// Throughput: one pixel pair per cycle from the back-end row stepper when not stalled;
// a quad gives 2^(TILE_WIDTH_LOG2+TILE_HEIGHT_LOG2-1) pairs, 32 at the default tile.
// The two-entry setup queue takes the next quad while the current one is stepped.
// Reset (rst_ni low, asynchronous) empties the queue and the output register.
`default_nettype none
module grid_quad_texture_mapper_top #(
  parameter int unsigned TILE_WIDTH_LOG2  = gqtm_pkg::TILE_WIDTH_LOG2_DEF,
  parameter int unsigned TILE_HEIGHT_LOG2 = gqtm_pkg::TILE_HEIGHT_LOG2_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gqtm_quad_if.sink   quad_i,
  gqtm_pair_if.source pair_o
);
  import gqtm_pkg::*;

  setup_beat_t push, pop;
  logic        push_ready, pop_ready;

  gqtm_front #(
    .TILE_WIDTH_LOG2 (TILE_WIDTH_LOG2),
    .TILE_HEIGHT_LOG2(TILE_HEIGHT_LOG2)
  ) u_front (
    .quad_i      (quad_i),
    .push_o      (push),
    .push_ready_i(push_ready)
  );

  gqtm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .pop_o       (pop),
    .pop_ready_i (pop_ready)
  );

  gqtm_back #(
    .TILE_WIDTH_LOG2 (TILE_WIDTH_LOG2),
    .TILE_HEIGHT_LOG2(TILE_HEIGHT_LOG2)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_i      (pop),
    .pop_ready_o(pop_ready),
    .pair_o     (pair_o)
  );

endmodule
`default_nettype wire

// File: tb/tb_grid_quad_texture_mapper_top.sv
// Self-checking testbench for the grid quad texture mapper: directed quads, then random quads.
module tb_grid_quad_texture_mapper_top;
  import gqtm_pkg::*;

  localparam int unsigned W_LOG2         = TILE_WIDTH_LOG2_DEF;
  localparam int unsigned H_LOG2         = TILE_HEIGHT_LOG2_DEF;
  localparam int unsigned ROWS           = 1 << H_LOG2;
  localparam int unsigned PAIRS_PER_ROW  = (1 << W_LOG2) >> 1;
  localparam int unsigned PAIRS_PER_QUAD = ROWS * PAIRS_PER_ROW;
  localparam int unsigned RANDOM_QUADS   = 156;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned PRINT_LIMIT    = 30;

  typedef struct {
    quad_t       quad;
    bit          is_flat;
    logic [15:0] flat_index;
    logic [2:0]  flat_shift;
  } directed_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  gqtm_quad_if quad_if ();
  gqtm_pair_if pair_if ();

  grid_quad_texture_mapper_top #(
    .TILE_WIDTH_LOG2  (W_LOG2),
    .TILE_HEIGHT_LOG2 (H_LOG2)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .quad_i (quad_if),
    .pair_o (pair_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pair_t         expected_pairs[$];
  directed_row_t directed_rows[$];
  int unsigned   quads_sent;
  int unsigned   pairs_checked;
  int unsigned   mismatch_count;
  int unsigned   stall_cycles;
  bit            steady;

  function automatic logic [31:0] sext16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] shift_right_arith(input logic [31:0] x, input int unsigned k);
    logic signed [31:0] sx;
    sx = x;
    return sx >>> k;
  endfunction

  // Bilinear stepping of one quad; every pair beat it will produce goes to the queue.
  function automatic void predict_quad_pairs(input quad_t q);
    logic [31:0] tlu, tlv, tru, trv, blu, blv, bru, brv, tls, trs, bls, brs;
    logic [31:0] edge_uv, edge_uv_inc, span_du, span_dv, span_du_inc, span_dv_inc;
    logic [31:0] edge_shade, edge_shade_inc, shade_grad, shade_grad_inc;
    logic [31:0] uv, uv_inc, lanes, lanes_inc, t_a, t_b;
    logic [15:0] lane_base, lane_delta;
    pair_t p;
    tlu = sext16(q.tl_u);
    tlv = sext16(q.tl_v);
    tru = sext16(q.tr_u);
    trv = sext16(q.tr_v);
    blu = sext16(q.bl_u);
    blv = sext16(q.bl_v);
    bru = sext16(q.br_u);
    brv = sext16(q.br_v);
    tls = {13'b0, q.tl_shade};
    trs = {13'b0, q.tr_shade};
    bls = {13'b0, q.bl_shade};
    brs = {13'b0, q.br_shade};

    edge_uv     = {tlu[15:0], tlv[15:0]};
    t_a         = shift_right_arith(blu - tlu, H_LOG2);
    t_b         = shift_right_arith(blv - tlv, H_LOG2);
    edge_uv_inc = {t_a[15:0], t_b[15:0]};
    span_du     = tru - tlu;
    span_du_inc = shift_right_arith((bru - blu) - span_du, H_LOG2);
    span_dv     = trv - tlv;
    span_dv_inc = shift_right_arith((brv - blv) - span_dv, H_LOG2);

    edge_shade     = tls;
    edge_shade_inc = shift_right_arith(bls - tls, H_LOG2);
    t_a            = trs - tls;
    t_b            = shift_right_arith((brs - bls) - t_a, H_LOG2);
    shade_grad     = shift_right_arith(t_a, W_LOG2);
    shade_grad_inc = shift_right_arith(t_b, W_LOG2);

    for (int unsigned r = 0; r < ROWS; r++) begin
      t_a    = shift_right_arith(span_du, W_LOG2);
      t_b    = shift_right_arith(span_dv, W_LOG2);
      uv_inc = {t_a[15:0], t_b[15:0]};
      t_a        = shift_right_arith(shade_grad, SHADE_FRAC_SHIFT);
      t_b        = shift_right_arith(edge_shade, SHADE_FRAC_SHIFT);
      lane_delta = t_a[15:0];
      lane_base  = t_b[15:0];
      // Two shade lanes share one adder, so a low-lane carry lands in the high lane.
      lanes     = {lane_base + lane_delta, lane_base};
      lanes_inc = {lane_delta, lane_delta} << 1;
      uv        = edge_uv;
      for (int unsigned k = 0; k < PAIRS_PER_ROW; k++) begin
        p.first_tex_index  = {uv[15:8], uv[31:24]};
        p.first_shift      = lanes[15:13];
        uv                 = uv + uv_inc;
        p.second_tex_index = {uv[15:8], uv[31:24]};
        p.second_shift     = lanes[31:29];
        uv                 = uv + uv_inc;
        lanes              = lanes + lanes_inc;
        p.last             = (r == ROWS - 1) && (k == PAIRS_PER_ROW - 1);
        expected_pairs.push_back(p);
      end
      edge_uv    = edge_uv + edge_uv_inc;
      edge_shade = edge_shade + edge_shade_inc;
      shade_grad = shade_grad + shade_grad_inc;
      span_du    = span_du + span_du_inc;
      span_dv    = span_dv + span_dv_inc;
    end
  endfunction

  function automatic quad_t corners(
    input logic [15:0] tlu, input logic [15:0] tlv, input logic [18:0] tls,
    input logic [15:0] tru, input logic [15:0] trv, input logic [18:0] trs,
    input logic [15:0] blu, input logic [15:0] blv, input logic [18:0] bls,
    input logic [15:0] bru, input logic [15:0] brv, input logic [18:0] brs
  );
    return {tlu, tlv, tls, tru, trv, trs, blu, blv, bls, bru, brv, brs};
  endfunction

  function automatic logic [31:0] near(input logic [31:0] base, input int unsigned span);
    return base + $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [18:0] pick_shade();
    case ($urandom_range(0, 3))
      0:       return 19'h00000;
      1:       return 19'h7ffff;
      2:       return 19'h40000;
      default: return 19'($urandom);
    endcase
  endfunction

  // Mostly grid-like quads with nearby corners, some fully random, some at the extremes.
  function automatic quad_t random_quad();
    quad_t        q;
    int unsigned  style, uv_span, shade_span;
    logic [31:0]  bu, bv, bs;
    logic [223:0] raw;
    style = $urandom_range(0, 9);
    if (style < 2) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      q   = raw[$bits(quad_t)-1:0];
    end else if (style < 4) begin
      q = corners(pick_coord(), pick_coord(), pick_shade(), pick_coord(), pick_coord(),
                  pick_shade(), pick_coord(), pick_coord(), pick_shade(), pick_coord(),
                  pick_coord(), pick_shade());
    end else begin
      uv_span    = (style < 8) ? 32'h0400 : 32'h3000;
      shade_span = (style < 8) ? 32'h2000 : 32'h20000;
      bu = $urandom;
      bv = $urandom;
      bs = $urandom;
      q = corners(16'(near(bu, uv_span)), 16'(near(bv, uv_span)),
                  19'(near(bs, shade_span)),
                  16'(near(bu, uv_span)), 16'(near(bv, uv_span)),
                  19'(near(bs, shade_span)),
                  16'(near(bu, uv_span)), 16'(near(bv, uv_span)),
                  19'(near(bs, shade_span)),
                  16'(near(bu, uv_span)), 16'(near(bv, uv_span)),
                  19'(near(bs, shade_span)));
    end
    return q;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("MISMATCH at pair %0d: %s got %0h, expected %0h", pairs_checked, what, got,
               want);
    end
  endtask

  task automatic send_quad(input quad_t q);
    int unsigned gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      quad_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    quad_if.valid <= 1'b1;
    quad_if.data  <= q;
    do @(posedge clk_i); while (!quad_if.ready);
    quads_sent++;
  endtask

  // Pair sink: random bursts of ready with stalls in between, none in a steady stretch.
  initial begin
    int unsigned gap;
    forever begin
      gap = steady ? 0 : idle_len();
      if (gap > 0) begin
        pair_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pair_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    pair_t want;
    if (rst_ni && pair_if.valid && pair_if.ready) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch("pair beat with no quad pending, index", pair_if.data.first_tex_index,
                        16'd0);
      end else begin
        want = expected_pairs.pop_front();
        if (pair_if.data.first_tex_index !== want.first_tex_index)
          report_mismatch("first_tex_index", pair_if.data.first_tex_index,
                          want.first_tex_index);
        if (pair_if.data.first_shift !== want.first_shift)
          report_mismatch("first_shift", 16'(pair_if.data.first_shift),
                          16'(want.first_shift));
        if (pair_if.data.second_tex_index !== want.second_tex_index)
          report_mismatch("second_tex_index", pair_if.data.second_tex_index,
                          want.second_tex_index);
        if (pair_if.data.second_shift !== want.second_shift)
          report_mismatch("second_shift", 16'(pair_if.data.second_shift),
                          16'(want.second_shift));
        if (pair_if.data.last !== want.last)
          report_mismatch("last", 16'(pair_if.data.last), 16'(want.last));
      end
      pairs_checked++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (quad_if.valid && quad_if.ready) || (pair_if.valid && pair_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    pair_t flat;
    quad_t q;
    quad_if.valid <= 1'b0;
    quad_if.data  <= '0;
    steady        = 1'b0;

    // Uniform quads: every pair reads the same texel with the top-left shade.
    directed_rows.push_back('{corners(16'h0000, 16'h0000, 19'h00000, 16'h0000, 16'h0000,
      19'h00000, 16'h0000, 16'h0000, 19'h00000, 16'h0000, 16'h0000, 19'h00000),
      1'b1, 16'h0000, 3'd0});
    directed_rows.push_back('{corners(16'h7fff, 16'h7fff, 19'h7ffff, 16'h7fff, 16'h7fff,
      19'h7ffff, 16'h7fff, 16'h7fff, 19'h7ffff, 16'h7fff, 16'h7fff, 19'h7ffff),
      1'b1, 16'h7f7f, 3'd7});
    directed_rows.push_back('{corners(16'h8000, 16'h8000, 19'h00000, 16'h8000, 16'h8000,
      19'h00000, 16'h8000, 16'h8000, 19'h00000, 16'h8000, 16'h8000, 19'h00000),
      1'b1, 16'h8080, 3'd0});
    directed_rows.push_back('{corners(16'h1234, 16'h5678, 19'h5a5a5, 16'h1234, 16'h5678,
      19'h5a5a5, 16'h1234, 16'h5678, 19'h5a5a5, 16'h1234, 16'h5678, 19'h5a5a5),
      1'b1, 16'h5612, 3'd5});
    directed_rows.push_back('{corners(16'hff00, 16'h0080, 19'h30000, 16'hff00, 16'h0080,
      19'h30000, 16'hff00, 16'h0080, 19'h30000, 16'hff00, 16'h0080, 19'h30000),
      1'b1, 16'h00ff, 3'd3});
    // Ramps, full-range diagonals, packed carries and twisted quads.
    directed_rows.push_back('{corners(16'h0000, 16'h0000, 19'h00000, 16'h0800, 16'h0000,
      19'h00000, 16'h0000, 16'h0000, 19'h00000, 16'h0800, 16'h0000, 19'h00000),
      1'b0, 16'h0, 3'd0});
    directed_rows.push_back('{corners(16'h0000, 16'h0000, 19'h00000, 16'h0000, 16'h0000,
      19'h00000, 16'h0000, 16'h0800, 19'h00000, 16'h0000, 16'h0800, 19'h00000),
      1'b0, 16'h0, 3'd0});
    directed_rows.push_back('{corners(16'h8000, 16'h8000, 19'h00000, 16'h7fff, 16'h8000,
      19'h7ffff, 16'h8000, 16'h7fff, 19'h00000, 16'h7fff, 16'h7fff, 19'h7ffff),
      1'b0, 16'h0, 3'd0});
    directed_rows.push_back('{corners(16'h7fff, 16'h7fff, 19'h7ffff, 16'h8000, 16'h7fff,
      19'h00000, 16'h7fff, 16'h8000, 19'h7ffff, 16'h8000, 16'h8000, 19'h00000),
      1'b0, 16'h0, 3'd0});
    directed_rows.push_back('{corners(16'h1000, 16'hff00, 19'h10000, 16'h1000, 16'h7f00,
      19'h10000, 16'h1000, 16'hff00, 19'h10000, 16'h1000, 16'h7f00, 19'h10000),
      1'b0, 16'h0, 3'd0});
    directed_rows.push_back('{corners(16'h0000, 16'h0000, 19'h7ff00, 16'h0000, 16'h0000,
      19'h7ffff, 16'h0000, 16'h0000, 19'h7ff00, 16'h0000, 16'h0000, 19'h7ffff),
      1'b0, 16'h0, 3'd0});
    directed_rows.push_back('{corners(16'h0300, 16'h0500, 19'h7ffff, 16'h0300, 16'h0500,
      19'h00000, 16'h0300, 16'h0500, 19'h40000, 16'h0300, 16'h0500, 19'h00100),
      1'b0, 16'h0, 3'd0});
    directed_rows.push_back('{corners(16'h0000, 16'h0000, 19'h08000, 16'h4000, 16'h1000,
      19'h28000, 16'h1000, 16'h4000, 19'h50000, 16'h7000, 16'h7000, 19'h1c000),
      1'b0, 16'h0, 3'd0});
    directed_rows.push_back('{corners(16'h2000, 16'h2000, 19'h60000, 16'he000, 16'h2000,
      19'h20000, 16'h2000, 16'he000, 19'h40000, 16'he000, 16'he000, 19'h00000),
      1'b0, 16'h0, 3'd0});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_flat) begin
        for (int unsigned k = 0; k < PAIRS_PER_QUAD; k++) begin
          flat.first_tex_index  = directed_rows[i].flat_index;
          flat.first_shift      = directed_rows[i].flat_shift;
          flat.second_tex_index = directed_rows[i].flat_index;
          flat.second_shift     = directed_rows[i].flat_shift;
          flat.last             = (k == PAIRS_PER_QUAD - 1);
          expected_pairs.push_back(flat);
        end
      end else begin
        predict_quad_pairs(directed_rows[i].quad);
      end
      send_quad(directed_rows[i].quad);
    end

    for (int unsigned n = 0; n < RANDOM_QUADS; n++) begin
      // Now and then a stretch where neither side idles.
      if (n % 25 == 0) steady = ($urandom_range(0, 3) == 0);
      q = random_quad();
      predict_quad_pairs(q);
      send_quad(q);
    end
    quad_if.valid <= 1'b0;

    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d quads (%0d from the directed table) and %0d pixel pairs.",
             quads_sent, directed_rows.size(), pairs_checked);
    $display("Mismatched fields: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/gqtm_pkg.sv
hw/rtl/gqtm_if.sv
hw/rtl/gqtm_front.sv
hw/rtl/gqtm_queue.sv
hw/rtl/gqtm_back.sv
hw/rtl/grid_quad_texture_mapper_top.sv
tb/tb_grid_quad_texture_mapper_top.sv
